// ===== hw/rtl/pcgnms_pkg.sv =====
package pcgnms_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned CLASS_W = 6;
    localparam int unsigned AREA_W  = 32;
    localparam int unsigned THR_W   = 16;
    localparam int unsigned UNION_W = AREA_W + 1;
    localparam int unsigned LHS_W   = AREA_W + 16;
    localparam int unsigned RHS_W   = THR_W + UNION_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [AREA_W-1:0]  area_t;

    // stored box: corners x0, y0, x1, y1 low to high, then class and area
    typedef struct packed {
        area_t  area;
        class_t cls;
        coord_t y1;
        coord_t x1;
        coord_t y0;
        coord_t x0;
    } kept_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AREA,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } nms_state_t;

    function automatic coord_t span16(input coord_t lo, input coord_t hi);
        span16 = (hi > lo) ? coord_t'(hi - lo) : '0;
    endfunction

endpackage

// ===== hw/rtl/per_class_greedy_nms_core.sv =====
// Per-class greedy non-maximum suppression over a stream of detection boxes.
// Boxes enter on the s_ channel in descending score order, one beat per box.
// Each box is tested against every box kept so far in the current set; only
// boxes of the same class take part. A box is suppressed when
// inter * 65536 > overlap threshold * union with a nonzero union. Survivors are
// stored with their area until MAX_KEPT boxes are held; a survivor beyond that
// is reported with table_overflow set and not stored. first_of_set (s_tuser)
// empties the table before its box is handled.
// One result beat on m_ per input beat: bit 0 kept, bit 1 table_overflow.
// After the accept the block takes one area step, then one read of the kept-box
// memory per stored box, then drains a five-stage compare pipeline before the
// result loads. The next box may enter in the cycle after the result loads.
// s_tready is high only while the block waits for a box; a result held by a
// stalled receiver does not block the next accept, but the block then waits
// in its result state until the output register frees.
// Reset empties the table and loads the overlap threshold with 29491; the memory
// is not cleared. The threshold is written on the cfg_ channel, by the user only
// while idle; the block itself does not enforce this.
module per_class_greedy_nms_core #(
    parameter int unsigned MAX_KEPT = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [15:0] left_edge, [31:16] top_edge, [47:32] right_edge,
    // [63:48] bottom_edge, [69:64] class_label, [71:70] zero
    input  logic [71:0]               s_tdata,
    // [0] first_of_set
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] kept, [1] table_overflow, [7:2] zero
    output logic [7:0]                m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [pcgnms_pkg::THR_W-1:0] cfg_data
);
    import pcgnms_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int unsigned ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int unsigned PIPE_N = 5;

    nms_state_t state_reg, state_next;

    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;

    coord_t x0_reg, y0_reg, x1_reg, y1_reg;
    class_t cls_reg;
    coord_t wx_reg, wy_reg;
    area_t  area_reg;
    logic   suppress_reg;

    kept_entry_t kept_mem [MAX_KEPT];
    kept_entry_t rd_entry_reg;
    kept_entry_t wr_entry;

    logic [PIPE_N-1:0] vld_reg;

    // comparison pipeline stages
    coord_t              s2_wx_reg, s2_wy_reg;
    area_t               s2_karea_reg;
    logic                s2_match_reg;
    logic [AREA_W-1:0]   s3_inter_reg;
    area_t               s3_karea_reg;
    logic                s3_match_reg;
    logic [AREA_W-1:0]   s4_inter_reg;
    logic [UNION_W-1:0]  s4_union_reg;
    logic                s4_match_reg;
    logic [LHS_W-1:0]    s5_lhs_reg;
    logic [RHS_W-1:0]    s5_rhs_reg;
    logic                s5_hit_reg;
    logic                s5_over;

    logic m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    logic in_fire, issue, resp_fire, can_store, store;

    assign in_fire   = s_tvalid && s_tready;
    assign can_store = (count_reg < CNT_W'(MAX_KEPT));
    assign store     = resp_fire && !suppress_reg && can_store;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire) state_next = ST_AREA;
            ST_AREA:  state_next = ST_SCAN;
            ST_SCAN:  if (idx_reg >= count_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (vld_reg == '0) state_next = ST_RESP;
            ST_RESP:  if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready  = 1'b0;
        issue     = 1'b0;
        resp_fire = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready  = 1'b1;
            ST_SCAN:  issue     = (idx_reg < count_reg);
            ST_RESP:  resp_fire = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (in_fire && s_tuser) begin
            count_next = '0;
        end else if (store) begin
            count_next = count_reg + 1'b1;
        end
        idx_next = idx_reg;
        if (state_reg == ST_AREA) begin
            idx_next = '0;
        end else if (issue) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb begin
        wr_entry.x0   = x0_reg;
        wr_entry.y0   = y0_reg;
        wr_entry.x1   = x1_reg;
        wr_entry.y1   = y1_reg;
        wr_entry.cls  = cls_reg;
        wr_entry.area = area_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THR_RESET;
            count_reg    <= '0;
            idx_reg      <= '0;
            vld_reg      <= '0;
            suppress_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            vld_reg   <= {vld_reg[PIPE_N-2:0], issue};
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (in_fire) begin
                suppress_reg <= 1'b0;
            end else if (vld_reg[PIPE_N-1] && s5_hit_reg && s5_over) begin
                suppress_reg <= 1'b1;
            end
            if (resp_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // box payload and result
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            x0_reg  <= s_tdata[15:0];
            y0_reg  <= s_tdata[31:16];
            x1_reg  <= s_tdata[47:32];
            y1_reg  <= s_tdata[63:48];
            cls_reg <= s_tdata[69:64];
            wx_reg  <= span16(s_tdata[15:0], s_tdata[47:32]);
            wy_reg  <= span16(s_tdata[31:16], s_tdata[63:48]);
        end
        if (state_reg == ST_AREA) begin
            area_reg <= AREA_W'(wx_reg) * AREA_W'(wy_reg);
        end
        if (resp_fire) begin
            m_tdata_reg <= {6'b0, !suppress_reg && !can_store, !suppress_reg};
        end
    end

    // kept-box memory
    always_ff @(posedge aclk) begin
        if (store) begin
            kept_mem[count_reg[ADDR_W-1:0]] <= wr_entry;
        end
        rd_entry_reg <= kept_mem[idx_reg[ADDR_W-1:0]];
    end

    // comparison pipeline
    always_ff @(posedge aclk) begin
        s2_wx_reg    <= span16((x0_reg > rd_entry_reg.x0) ? x0_reg : rd_entry_reg.x0,
                               (x1_reg < rd_entry_reg.x1) ? x1_reg : rd_entry_reg.x1);
        s2_wy_reg    <= span16((y0_reg > rd_entry_reg.y0) ? y0_reg : rd_entry_reg.y0,
                               (y1_reg < rd_entry_reg.y1) ? y1_reg : rd_entry_reg.y1);
        s2_karea_reg <= rd_entry_reg.area;
        s2_match_reg <= (rd_entry_reg.cls == cls_reg);

        s3_inter_reg <= AREA_W'(s2_wx_reg) * AREA_W'(s2_wy_reg);
        s3_karea_reg <= s2_karea_reg;
        s3_match_reg <= s2_match_reg;

        // inter never exceeds either area, so the union stays nonnegative
        s4_union_reg <= UNION_W'(area_reg) + UNION_W'(s3_karea_reg)
                        - UNION_W'(s3_inter_reg);
        s4_inter_reg <= s3_inter_reg;
        s4_match_reg <= s3_match_reg;

        s5_lhs_reg <= {s4_inter_reg, 16'b0};
        s5_rhs_reg <= RHS_W'(thr_reg) * RHS_W'(s4_union_reg);
        s5_hit_reg <= s4_match_reg && (s4_union_reg != '0);
    end

    assign s5_over = (RHS_W'(s5_lhs_reg) > s5_rhs_reg);

endmodule

// ===== bench/per_class_greedy_nms_core_tb.sv =====
module per_class_greedy_nms_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcgnms_pkg::*;

    localparam int unsigned MAX_KEPT    = 64;
    localparam int unsigned PHASES      = 7;
    localparam int unsigned PHASE_ITEMS = 90;
    localparam int unsigned CYCLE_LIMIT = 500000;

    // x0 in the low bits, class on top: same order as s_tdata
    typedef struct packed {
        class_t cls;
        coord_t y1;
        coord_t x1;
        coord_t y0;
        coord_t x0;
    } box_t;

    typedef struct packed {
        logic ovf;
        logic kept;
    } verdict_t;

    class nms_scoreboard;
        box_t            kept_boxes[MAX_KEPT];
        logic [31:0]     kept_areas[MAX_KEPT];
        int unsigned     stored_count;
        logic [15:0]     threshold;
        verdict_t        pending_verdicts[$];
        int unsigned     mismatches;
        int unsigned     boxes_seen;
        int unsigned     kept_total;
        int unsigned     suppressed_total;
        int unsigned     overflow_total;

        function new();
            stored_count = 0;
            threshold = THR_RESET;
            mismatches = 0;
            boxes_seen = 0;
            kept_total = 0;
            suppressed_total = 0;
            overflow_total = 0;
        endfunction

        function void set_threshold(logic [15:0] value);
            threshold = value;
        endfunction

        function int unsigned pending();
            return pending_verdicts.size();
        endfunction

        function longint unsigned side_len(coord_t lo, coord_t hi);
            return (hi > lo) ? 64'(hi) - 64'(lo) : 64'd0;
        endfunction

        // run the greedy test for one accepted box and queue its verdict
        function void note_box(logic first, box_t b);
            longint unsigned area;
            longint unsigned inter;
            longint unsigned uni;
            coord_t          ix0, iy0, ix1, iy1;
            box_t            k;
            verdict_t        v;
            area = side_len(b.x0, b.x1) * side_len(b.y0, b.y1);
            if (first)
                stored_count = 0;
            v.kept = 1'b1;
            v.ovf = 1'b0;
            for (int i = 0; i < stored_count; i++) begin
                k = kept_boxes[i];
                if (k.cls == b.cls) begin
                    ix0 = (b.x0 > k.x0) ? b.x0 : k.x0;
                    iy0 = (b.y0 > k.y0) ? b.y0 : k.y0;
                    ix1 = (b.x1 < k.x1) ? b.x1 : k.x1;
                    iy1 = (b.y1 < k.y1) ? b.y1 : k.y1;
                    inter = side_len(ix0, ix1) * side_len(iy0, iy1);
                    uni = area + 64'(kept_areas[i]) - inter;
                    if (uni != 0 && (inter << 16) > 64'(threshold) * uni) begin
                        v.kept = 1'b0;
                        break;
                    end
                end
            end
            if (v.kept) begin
                if (stored_count < MAX_KEPT) begin
                    kept_boxes[stored_count] = b;
                    kept_areas[stored_count] = area[31:0];
                    stored_count++;
                end else begin
                    v.ovf = 1'b1;
                end
            end
            boxes_seen++;
            pending_verdicts.insert(pending_verdicts.size(), v);
        endfunction

        function void check_verdict(logic [7:0] data);
            verdict_t want;
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                $display("%0t: result beat %h arrived with no box pending", $time, data);
                return;
            end
            want = pending_verdicts.pop_front();
            if (data[0] !== want.kept) begin
                mismatches++;
                $display("%0t: kept expected %b actual %b", $time, want.kept, data[0]);
            end
            if (data[1] !== want.ovf) begin
                mismatches++;
                $display("%0t: table_overflow expected %b actual %b",
                         $time, want.ovf, data[1]);
            end
            if (data[7:2] !== 6'd0) begin
                mismatches++;
                $display("%0t: padding expected 00 actual %h", $time, data[7:2]);
            end
            if (want.ovf)
                overflow_total++;
            else if (want.kept)
                kept_total++;
            else
                suppressed_total++;
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [71:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [THR_W-1:0]     cfg_data;

    nms_scoreboard        sb;
    logic                 no_idle;
    int unsigned          cycle_count;

    per_class_greedy_nms_core #(
        .MAX_KEPT(MAX_KEPT)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        no_idle = 1'b0;
        cycle_count = 0;
        sb = new();
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic coord_t clamp_coord(int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return 16'hFFFF;
        return coord_t'(v);
    endfunction

    // mostly jittered boxes around a center, some fully random or inverted
    function automatic box_t scatter_box(int cx, int cy, class_t cls);
        box_t b;
        int   w, h, mode;
        mode = $urandom_range(0, 19);
        b.cls = cls;
        if (mode == 0) begin
            b.x0 = coord_t'($urandom);
            b.y0 = coord_t'($urandom);
            b.x1 = coord_t'($urandom);
            b.y1 = coord_t'($urandom);
            b.cls = class_t'($urandom);
        end else if (mode == 1) begin
            b.x0 = coord_t'($urandom);
            b.y0 = coord_t'($urandom);
            b.x1 = coord_t'($urandom_range(0, b.x0));
            b.y1 = coord_t'($urandom);
        end else begin
            w = $urandom_range(1, 3000);
            h = $urandom_range(1, 3000);
            cx = cx + int'($urandom_range(0, w / 2)) - w / 4;
            cy = cy + int'($urandom_range(0, h / 2)) - h / 4;
            b.x0 = clamp_coord(cx - w / 2);
            b.y0 = clamp_coord(cy - h / 2);
            b.x1 = clamp_coord(cx - w / 2 + w);
            b.y1 = clamp_coord(cy - h / 2 + h);
        end
        return b;
    endfunction

    // drive one box beat; returns at the falling edge after acceptance, tvalid held
    task automatic send_box(input logic first, input box_t b);
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {2'b00, b};
        s_tuser <= first;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_box(first, b);
        @(negedge aclk);
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_verdicts();
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    task automatic load_threshold(input logic [15:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_threshold(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic box_t make_box(int x0, int y0, int x1, int y1, int cls);
        box_t b;
        b.x0 = coord_t'(x0);
        b.y0 = coord_t'(y0);
        b.x1 = coord_t'(x1);
        b.y1 = coord_t'(y1);
        b.cls = class_t'(cls);
        return b;
    endfunction

    // 64 disjoint boxes of one class fill the table, then extras overflow or drop
    task automatic send_tiled_set(output int unsigned count);
        box_t   tiles[MAX_KEPT];
        box_t   b;
        class_t cls;
        int     x, y;
        count = $urandom_range(MAX_KEPT, MAX_KEPT + 8);
        cls = class_t'($urandom);
        for (int k = 0; k < count; k++) begin
            if (k < MAX_KEPT) begin
                x = (k % 8) * 8192 + int'($urandom_range(0, 3000));
                y = (k / 8) * 8192 + int'($urandom_range(0, 3000));
                b = make_box(x, y, x + int'($urandom_range(1, 5000)),
                             y + int'($urandom_range(1, 5000)), cls);
                tiles[k] = b;
            end else if ($urandom_range(0, 1) == 0) begin
                b = tiles[$urandom_range(0, MAX_KEPT - 1)];
            end else begin
                b = scatter_box($urandom_range(0, 65535), $urandom_range(0, 65535), cls);
                b.cls = cls;
            end
            send_box(k == 0, b);
        end
    endtask

    task automatic send_random_set(output int unsigned count);
        int     cx[3];
        int     cy[3];
        class_t pool[2];
        int     c;
        logic   first;
        count = $urandom_range(1, 14);
        for (int i = 0; i < 3; i++) begin
            cx[i] = $urandom_range(0, 65535);
            cy[i] = $urandom_range(0, 65535);
        end
        pool[0] = class_t'($urandom);
        pool[1] = ($urandom_range(0, 2) == 0) ? class_t'($urandom) : pool[0];
        for (int k = 0; k < count; k++) begin
            c = $urandom_range(0, 2);
            // a stray set start now and then breaks the set early
            first = (k == 0) ? 1'b1 : ($urandom_range(0, 29) == 0);
            send_box(first, scatter_box(cx[c], cy[c], pool[$urandom_range(0, 1)]));
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_verdict(m_tdata);
            @(negedge aclk);
        end
    end

    initial begin : box_source
        logic [15:0] thresholds[PHASES];
        int unsigned sent;
        int unsigned n;
        thresholds[0] = THR_RESET;
        thresholds[1] = 16'd0;
        thresholds[2] = 16'hFFFF;
        thresholds[3] = 16'd32768;
        thresholds[4] = 16'($urandom_range(0, 65535));
        thresholds[5] = THR_RESET;
        thresholds[6] = 16'd1;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed boxes under the reset threshold
        send_box(1'b1, make_box(0, 0, 65535, 65535, 0));
        send_box(1'b0, make_box(0, 0, 65535, 65535, 0));      // identical: drop
        send_box(1'b0, make_box(0, 0, 65535, 65535, 63));     // other class: keep
        send_box(1'b0, make_box(0, 0, 32768, 65535, 0));      // half overlap
        send_box(1'b0, make_box(100, 100, 50, 200, 1));       // inverted
        send_box(1'b0, make_box(100, 100, 50, 200, 1));       // zero union
        send_box(1'b0, make_box(300, 300, 300, 400, 1));      // empty
        send_box(1'b0, make_box(65535, 65535, 0, 0, 2));
        send_box(1'b1, make_box(0, 0, 1, 1, 5));              // set restart
        send_box(1'b0, make_box(0, 0, 1, 1, 5));
        send_box(1'b0, make_box(0, 0, 2, 2, 5));
        send_box(1'b0, make_box(1, 1, 3, 3, 5));
        send_box(1'b0, make_box(65534, 65534, 65535, 65535, 42));
        send_box(1'b0, make_box(65534, 65534, 65535, 65535, 42));
        send_box(1'b0, make_box(0, 65535, 65535, 0, 21));

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                release_input();
                drain_verdicts();
                load_threshold(thresholds[p]);
            end
            no_idle = (p == 3);
            sent = 0;
            if (p == 0 || p == 2 || p == 5) begin
                send_tiled_set(n);
                sent += n;
            end
            while (sent < PHASE_ITEMS) begin
                if (p != 3)
                    no_idle = ($urandom_range(0, 5) == 0);
                send_random_set(n);
                sent += n;
            end
        end
        release_input();
        no_idle = 1'b0;
        drain_verdicts();
        repeat (100) @(negedge aclk);

        $display("%0d boxes over %0d threshold settings, tiled sets to fill the table",
                 sb.boxes_seen, PHASES);
        $display("verdicts: %0d kept, %0d suppressed, %0d overflowed",
                 sb.kept_total, sb.suppressed_total, sb.overflow_total);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
